>>> rtl/bal_pkg.sv
// ============================================================================
// bal_pkg
// Shared types and fixed constants of the block-average luma glyph quantizer.
// ============================================================================
`default_nettype none

package bal_pkg;

    // Field widths fixed by the item formats
    localparam int CHW   = 8;   // color channel
    localparam int CFGW  = 11;  // config data
    localparam int CIDXW = 2;   // config register index
    localparam int PALW  = 5;   // palette size register
    localparam int GLW   = 4;   // glyph index

    // Accumulator widths
    localparam int LUMW  = 24;  // one pixel luma, Q8.16
    localparam int SUMW  = 33;  // cell luma sum
    localparam int CNTW  = 9;   // cell pixel count
    localparam int CCW   = 8;   // cell column counter

    // Quantizer widths: sum*P against (count*255*(i+1)) << 16
    localparam int QSH   = 16;
    localparam int FMW   = 13;  // 255*31 fits
    localparam int LHSW  = SUMW + PALW;
    localparam int RHW   = CNTW + FMW;
    localparam int QCMPW = LHSW + 1;

    // Rec.709 weights in Q0.16, sum 65536
    localparam int unsigned WEIGHT_R = 13933;
    localparam int unsigned WEIGHT_G = 46871;
    localparam int unsigned WEIGHT_B = 4732;
    localparam int unsigned FULL_CODE = 255;

    // Register reset values
    localparam logic [CFGW-1:0] RST_WIDTH   = 11'd640;
    localparam logic [CFGW-1:0] RST_HEIGHT  = 11'd480;
    localparam logic [PALW-1:0] RST_PALETTE = 5'd10;

    // Result queue depth
    localparam int OUT_DEPTH = 8;

    // Config register indexes
    typedef enum logic [CIDXW-1:0] {
        CFG_WIDTH   = 2'd0,
        CFG_HEIGHT  = 2'd1,
        CFG_PALETTE = 2'd2
    } t_cfg_idx;

    // One result item
    typedef struct packed {
        logic [GLW-1:0] glyph_index;
        logic           end_of_line;
        logic           end_of_image;
    } t_result;

    // Q8.16 luma of one pixel
    function automatic logic [LUMW-1:0] luma_of(input logic [CHW-1:0] red,
                                                 input logic [CHW-1:0] green,
                                                 input logic [CHW-1:0] blue);
        int unsigned acc;
        acc = WEIGHT_R * 32'(red) + WEIGHT_G * 32'(green) + WEIGHT_B * 32'(blue);
        return LUMW'(acc);
    endfunction

endpackage

`default_nettype wire

>>> rtl/bal_if.sv
// ============================================================================
// bal_if
// Valid/ready channels of the luma glyph quantizer: pixel, glyph and config.
// ============================================================================
`default_nettype none

// Pixel channel
interface bal_pix_if;
    logic                     valid;
    logic                     ready;
    logic [bal_pkg::CHW-1:0]  red;
    logic [bal_pkg::CHW-1:0]  green;
    logic [bal_pkg::CHW-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Glyph result channel
interface bal_glyph_if;
    logic                     valid;
    logic                     ready;
    logic [bal_pkg::GLW-1:0]  glyph_index;
    logic                     end_of_line;
    logic                     end_of_image;

    modport source (output valid, output glyph_index, output end_of_line,
                    output end_of_image, input ready);
    modport sink   (input valid, input glyph_index, input end_of_line,
                    input end_of_image, output ready);
endinterface

// Config write channel
interface bal_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [bal_pkg::CIDXW-1:0] index;
    logic [bal_pkg::CFGW-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/bal_ram.sv
// ============================================================================
// bal_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ============================================================================
`default_nettype none

module bal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/block_average_luma_to_glyph_index.sv
// ============================================================================
// block_average_luma_to_glyph_index
// Averages Rec.709 luma over character cells and quantizes each to a glyph.
// ============================================================================
// Usage:
//   i_pix takes RGB pixels in raster order, one item per clock while ready.
//   o_glyph gives one item per closed cell: glyph index (0 = brightest end),
//   end-of-line and end-of-image flags. i_cfg writes image width, height and
//   palette size (index 0, 1, 2); a write to one of them restarts the image.
//   Write config only with no cell result pending; pixels are held off in
//   the cycle after a write while the cell geometry is recomputed.
//   A result item passes the accumulate, closed-sum and multiply registers,
//   then is compared and queued before it is presented on o_glyph.
//   Throughput: one pixel per cycle while i_pix.ready is high, set by the
//   single-port-write RAM of per-column sums, read on accept and written in
//   the next cycle, with a bypass for back-to-back hits on the same column.
//   Up to 8 results may be outstanding; when the receiver stalls, results
//   collect in an output queue and i_pix.ready drops once 8 are pending.
//   Reset restores the register defaults (640x480, 10 glyphs), starts a new
//   image and empties the pipeline; the sum RAM is not cleared, since the
//   first pixel of each cell overwrites its entry.
// ============================================================================
`default_nettype none

module block_average_luma_to_glyph_index #(
    parameter int MAX_WIDTH        = 1024,
    parameter int MAX_HEIGHT       = 1024,
    parameter int TEXT_COLUMNS     = 69,
    parameter int TEXT_ROWS        = 29,
    parameter int MAX_PALETTE      = 16,
    parameter int MAX_CELL_COLUMNS = 256
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    bal_pix_if.sink         i_pix,
    bal_cfg_if.sink         i_cfg,
    bal_glyph_if.source     o_glyph
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int CPW    = $clog2(MAX_WIDTH);
    localparam int RPW    = $clog2(MAX_HEIGHT);
    localparam int CW_MAX = (MAX_WIDTH / TEXT_COLUMNS < 1) ? 1 : MAX_WIDTH / TEXT_COLUMNS;
    localparam int CH_MAX = (MAX_HEIGHT / TEXT_ROWS < 1) ? 1 : MAX_HEIGHT / TEXT_ROWS;
    localparam int OXW    = $clog2(CW_MAX + 1);
    localparam int OYW    = $clog2(CH_MAX + 1);
    localparam int SLW    = $clog2(MAX_CELL_COLUMNS);
    localparam int MEMW   = bal_pkg::SUMW + bal_pkg::CNTW;
    localparam int PNW    = $clog2(bal_pkg::OUT_DEPTH + 1);
    localparam int QPW    = $clog2(bal_pkg::OUT_DEPTH);
    localparam int PMAX   = (MAX_PALETTE < 31) ? MAX_PALETTE : 31;
    localparam int NTH    = PMAX - 1;

    // Reciprocal constants for width/TEXT_COLUMNS and height/TEXT_ROWS
    localparam int SX      = WW + $clog2(TEXT_COLUMNS);
    localparam int RECIP_X = ((1 << SX) + TEXT_COLUMNS - 1) / TEXT_COLUMNS;
    localparam int PXW     = WW + $clog2(RECIP_X + 1);
    localparam int SY      = HW + $clog2(TEXT_ROWS);
    localparam int RECIP_Y = ((1 << SY) + TEXT_ROWS - 1) / TEXT_ROWS;
    localparam int PYW     = HW + $clog2(RECIP_Y + 1);

    // Cell column to RAM slot, cell column below 256
    function automatic logic [SLW-1:0] slot_of(input logic [bal_pkg::CCW-1:0] cc);
        logic [bal_pkg::CCW:0] v;
        v = {1'b0, cc};
        for (int k = 0; k < 4; k++) begin
            if (MAX_CELL_COLUMNS < 256 && 32'(v) >= MAX_CELL_COLUMNS) begin
                v = v - (bal_pkg::CCW + 1)'(MAX_CELL_COLUMNS);
            end
        end
        return SLW'(v);
    endfunction

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_acc, cfg_acc, out_acc, cfg_restart;
    logic r_settle;
    logic [PNW-1:0] r_pend;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !r_settle && (r_pend < PNW'(bal_pkg::OUT_DEPTH));
    assign in_acc  = i_pix.valid && i_pix.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign out_acc = o_glyph.valid && o_glyph.ready;

    // only a write to a defined register restarts the image
    assign cfg_restart = cfg_acc && (i_cfg.index == bal_pkg::CFG_WIDTH
                                     || i_cfg.index == bal_pkg::CFG_HEIGHT
                                     || i_cfg.index == bal_pkg::CFG_PALETTE);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [bal_pkg::CFGW-1:0] r_image_width, r_image_height;
    logic [bal_pkg::PALW-1:0] r_palette_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= bal_pkg::RST_WIDTH;
            r_image_height <= bal_pkg::RST_HEIGHT;
            r_palette_size <= bal_pkg::RST_PALETTE;
            r_settle       <= 1'b1;
        end else begin
            r_settle <= cfg_acc;
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    bal_pkg::CFG_WIDTH:   r_image_width  <= i_cfg.data;
                    bal_pkg::CFG_HEIGHT:  r_image_height <= i_cfg.data;
                    bal_pkg::CFG_PALETTE: r_palette_size <= bal_pkg::PALW'(i_cfg.data);
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Derived geometry, recomputed every cycle from the registers
    // ------------------------------------------------------------------
    logic [WW-1:0]  w_clamp, r_w;
    logic [HW-1:0]  h_clamp, r_h;
    logic [PXW-1:0] cw_prod;
    logic [PYW-1:0] ch_prod;
    logic [OXW-1:0] cw_raw, r_cw;
    logic [OYW-1:0] ch_raw, r_ch;
    logic [bal_pkg::PALW-1:0] p_clamp, r_p;

    always_comb begin
        if (r_image_width == '0) begin
            w_clamp = WW'(1);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_clamp = HW'(1);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h_clamp = HW'(MAX_HEIGHT);
        end else begin
            h_clamp = HW'(r_image_height);
        end
        if (32'(r_palette_size) > MAX_PALETTE) begin
            p_clamp = bal_pkg::PALW'(MAX_PALETTE);
        end else begin
            p_clamp = r_palette_size;
        end
        // exact floor division by reciprocal multiply
        cw_prod = PXW'(w_clamp) * PXW'(RECIP_X);
        ch_prod = PYW'(h_clamp) * PYW'(RECIP_Y);
        cw_raw  = OXW'(cw_prod >> SX);
        ch_raw  = OYW'(ch_prod >> SY);
    end

    always_ff @(posedge i_clk) begin
        r_w  <= w_clamp;
        r_h  <= h_clamp;
        r_p  <= p_clamp;
        r_cw <= (cw_raw == '0) ? OXW'(1) : cw_raw;
        r_ch <= (ch_raw == '0) ? OYW'(1) : ch_raw;
    end

    // ------------------------------------------------------------------
    // Raster position tracking at accept
    // ------------------------------------------------------------------
    logic [CPW-1:0]          r_col, n_col;
    logic [RPW-1:0]          r_row, n_row;
    logic [bal_pkg::CCW-1:0] r_cc, n_cc;
    logic [OXW-1:0]          r_ox, n_ox;
    logic [OYW-1:0]          r_oy, n_oy;
    logic s0_first, s0_last_col, s0_last_row, s0_right, s0_bottom, s0_close;
    logic [SLW-1:0] s0_slot;

    always_comb begin
        s0_slot     = slot_of(r_cc);
        s0_first    = (r_ox == '0) && (r_oy == '0);
        s0_last_col = (WW + 1)'(r_col) + (WW + 1)'(1) >= (WW + 1)'(r_w);
        s0_last_row = (HW + 1)'(r_row) + (HW + 1)'(1) >= (HW + 1)'(r_h);
        s0_right    = s0_last_col || ((OXW + 1)'(r_ox) + (OXW + 1)'(1) >= (OXW + 1)'(r_cw));
        s0_bottom   = s0_last_row || ((OYW + 1)'(r_oy) + (OYW + 1)'(1) >= (OYW + 1)'(r_ch));
        s0_close    = s0_right && s0_bottom;

        n_col = r_col;
        n_row = r_row;
        n_cc  = r_cc;
        n_ox  = r_ox;
        n_oy  = r_oy;
        priority if (cfg_restart) begin
            n_col = '0;
            n_row = '0;
            n_cc  = '0;
            n_ox  = '0;
            n_oy  = '0;
        end else if (in_acc) begin
            if (s0_last_col) begin
                n_col = '0;
                n_cc  = '0;
                n_ox  = '0;
                if (s0_last_row) begin
                    n_row = '0;
                    n_oy  = '0;
                end else begin
                    n_row = r_row + RPW'(1);
                    n_oy  = s0_bottom ? '0 : r_oy + OYW'(1);
                end
            end else begin
                n_col = r_col + CPW'(1);
                if (s0_right) begin
                    n_ox = '0;
                    n_cc = r_cc + bal_pkg::CCW'(1);
                end else begin
                    n_ox = r_ox + OXW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cc  <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_cc  <= n_cc;
            r_ox  <= n_ox;
            r_oy  <= n_oy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: accumulate into the column RAM
    // ------------------------------------------------------------------
    logic                      r_s1_v;
    logic [SLW-1:0]            r_s1_slot;
    logic                      r_s1_first, r_s1_close, r_s1_eol, r_s1_eoi, r_s1_hit;
    logic [bal_pkg::LUMW-1:0]  r_s1_luma;
    logic [MEMW-1:0]           ram_rd_data;
    logic [bal_pkg::SUMW-1:0]  r_fwd_sum, s1_base_sum, s1_sum;
    logic [bal_pkg::CNTW-1:0]  r_fwd_cnt, s1_base_cnt, s1_cnt;

    bal_ram #(
        .WIDTH (MEMW),
        .DEPTH (MAX_CELL_COLUMNS)
    ) u_sums (
        .i_clk     (i_clk),
        .i_wr_en   (r_s1_v),
        .i_wr_addr (r_s1_slot),
        .i_wr_data ({s1_sum, s1_cnt}),
        .i_rd_en   (in_acc),
        .i_rd_addr (s0_slot),
        .o_rd_data (ram_rd_data)
    );

    // base value: fresh cell, bypass of the write made at our read edge, or RAM
    always_comb begin
        priority if (r_s1_first) begin
            s1_base_sum = '0;
            s1_base_cnt = '0;
        end else if (r_s1_hit) begin
            s1_base_sum = r_fwd_sum;
            s1_base_cnt = r_fwd_cnt;
        end else begin
            s1_base_sum = ram_rd_data[MEMW-1 -: bal_pkg::SUMW];
            s1_base_cnt = ram_rd_data[bal_pkg::CNTW-1:0];
        end
        s1_sum = s1_base_sum + bal_pkg::SUMW'(r_s1_luma);
        s1_cnt = s1_base_cnt + bal_pkg::CNTW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_slot  <= s0_slot;
            r_s1_first <= s0_first;
            r_s1_close <= s0_close;
            r_s1_eol   <= s0_last_col;
            r_s1_eoi   <= s0_last_col && s0_last_row;
            r_s1_hit   <= r_s1_v && (r_s1_slot == s0_slot);
            r_s1_luma  <= bal_pkg::luma_of(i_pix.red, i_pix.green, i_pix.blue);
        end
        if (r_s1_v) begin
            r_fwd_sum <= s1_sum;
            r_fwd_cnt <= s1_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: closed cell sum and count
    // ------------------------------------------------------------------
    logic                     r_s2_v, r_s2_eol, r_s2_eoi;
    logic [bal_pkg::SUMW-1:0] r_s2_sum;
    logic [bal_pkg::CNTW-1:0] r_s2_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v && r_s1_close;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_sum <= s1_sum;
        r_s2_cnt <= s1_cnt;
        r_s2_eol <= r_s1_eol;
        r_s2_eoi <= r_s1_eoi;
    end

    // ------------------------------------------------------------------
    // Stage 3: scaled sum and per-threshold limits
    // ------------------------------------------------------------------
    logic                     r_s3_v, r_s3_eol, r_s3_eoi;
    logic [bal_pkg::LHSW-1:0] r_s3_lhs;
    logic [bal_pkg::RHW-1:0]  r_s3_rhs [NTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_lhs <= bal_pkg::LHSW'(r_s2_sum) * bal_pkg::LHSW'(r_p);
        for (int i = 0; i < NTH; i++) begin
            r_s3_rhs[i] <= bal_pkg::RHW'(r_s2_cnt)
                         * bal_pkg::RHW'(bal_pkg::FULL_CODE * 32'(i + 1));
        end
        r_s3_eol <= r_s2_eol;
        r_s3_eoi <= r_s2_eoi;
    end

    // first threshold met picks the glyph, none gives 0
    logic [bal_pkg::GLW-1:0] s3_glyph;

    always_comb begin
        s3_glyph = '0;
        for (int i = NTH - 1; i >= 0; i--) begin
            if (bal_pkg::PALW'(i + 1) < r_p
                && bal_pkg::QCMPW'(r_s3_lhs)
                   <= (bal_pkg::QCMPW'(r_s3_rhs[i]) << bal_pkg::QSH)) begin
                s3_glyph = bal_pkg::GLW'(r_p - bal_pkg::PALW'(i + 1));
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue and pending-result count
    // ------------------------------------------------------------------
    bal_pkg::t_result r_q [bal_pkg::OUT_DEPTH];
    logic [QPW-1:0]   r_wp, r_rp;
    logic [PNW-1:0]   r_fifo_cnt;

    always_ff @(posedge i_clk) begin
        if (r_s3_v) begin
            r_q[r_wp] <= '{glyph_index: s3_glyph, end_of_line: r_s3_eol,
                           end_of_image: r_s3_eoi};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_rp       <= '0;
            r_fifo_cnt <= '0;
            r_pend     <= '0;
        end else begin
            if (r_s3_v) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (out_acc) begin
                r_rp <= r_rp + QPW'(1);
            end
            unique case ({r_s3_v, out_acc})
                2'b10:   r_fifo_cnt <= r_fifo_cnt + PNW'(1);
                2'b01:   r_fifo_cnt <= r_fifo_cnt - PNW'(1);
                default: r_fifo_cnt <= r_fifo_cnt;
            endcase
            unique case ({in_acc && s0_close, out_acc})
                2'b10:   r_pend <= r_pend + PNW'(1);
                2'b01:   r_pend <= r_pend - PNW'(1);
                default: r_pend <= r_pend;
            endcase
        end
    end

    assign o_glyph.valid        = (r_fifo_cnt != '0);
    assign o_glyph.glyph_index  = r_q[r_rp].glyph_index;
    assign o_glyph.end_of_line  = r_q[r_rp].end_of_line;
    assign o_glyph.end_of_image = r_q[r_rp].end_of_image;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PNW'(bal_pkg::OUT_DEPTH))
        else $error("pending result count above queue depth");

    a_queue_in_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_cnt <= r_pend)
        else $error("queue holds more results than are pending");

    a_settle_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settle |-> !in_acc)
        else $error("pixel accepted while geometry settles");

    a_close_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> $past(r_s1_v && r_s1_close))
        else $error("closed cell without a closing pixel");

    a_image_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s0_last_col && s0_last_row |=>
            (r_col == '0) && (r_row == '0) && (r_cc == '0))
        else $error("position not wrapped after last pixel of image");

endmodule

`default_nettype wire
